// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers used by spectral_bin_shifter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge, suspended while reset is asserted
`define SBS_ASSERT_RST(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check on every rising edge, reset included
`define SBS_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hdl/sbs_pkg.sv -----
// ----------------------------------------------------------------------------
// sbs_pkg
// Shared types and constants of the spectral bin shifter.
// ----------------------------------------------------------------------------
`default_nettype none

package sbs_pkg;

	// Default frame size in bins
	localparam int NUM_BINS_DEF = 33;

	// Bin sample width and stream word width
	localparam int SAMPLE_W = 24;
	localparam int TDATA_W  = 2 * SAMPLE_W;

	// Configuration port
	localparam int CFG_DATA_W  = 7;
	localparam int CFG_INDEX_W = 2;
	localparam int SHIFT_W     = 7;
	localparam int OVL_W       = 2;

	// Signed source index width, covers bin index minus any shift
	localparam int SRC_W = 9;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ENABLE  = 2'd0,
		REG_SHIFT   = 2'd1,
		REG_OVERLAP = 2'd2
	} cfg_reg_t;

	localparam logic [OVL_W-1:0] OVL_NONE    = 2'd0;
	localparam logic [OVL_W-1:0] OVL_HALF    = 2'd1;
	localparam logic [OVL_W-1:0] OVL_QUARTER = 2'd2;

	// Frame rotation in quarter turns
	typedef enum logic [1:0] {
		ROT_0   = 2'd0,
		ROT_90  = 2'd1,
		ROT_180 = 2'd2,
		ROT_270 = 2'd3
	} rot_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] imag;
		logic signed [SAMPLE_W-1:0] re;
	} cplx_t;

	// Side information that travels with one read of the store
	typedef struct packed {
		rot_t rot;
		logic zero;
		logic last;
	} rd_meta_t;

endpackage

`default_nettype wire

// ----- hdl/sbs_bin_store.sv -----
// ----------------------------------------------------------------------------
// sbs_bin_store
// Frame store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sbs_bin_store #(
	parameter int DEPTH  = sbs_pkg::NUM_BINS_DEF,
	parameter int ADDR_W = $clog2(sbs_pkg::NUM_BINS_DEF)
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire sbs_pkg::cplx_t    wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output sbs_pkg::cplx_t         rd_data_s1
);
	import sbs_pkg::*;

	cplx_t mem [0:DEPTH-1];

	// Write a bin
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read a bin, hold the data until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- hdl/sbs_rotator.sv -----
// ----------------------------------------------------------------------------
// sbs_rotator
// Output stage: zero fill, quarter-turn rotation with saturating negation,
// and the result register toward the master side.
// ----------------------------------------------------------------------------
`default_nettype none

module sbs_rotator (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          valid_s1,
	input  wire sbs_pkg::rd_meta_t             meta_s1,
	input  wire sbs_pkg::cplx_t                data_s1,
	output logic                               take_s1,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [sbs_pkg::TDATA_W-1:0]        m_tdata,  // re [23:0], imag [47:24]
	output logic                               m_tlast   // frame_end
);
	import sbs_pkg::*;

	localparam logic signed [SAMPLE_W-1:0] MAX_S = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] MIN_S = {1'b1, {(SAMPLE_W-1){1'b0}}};

	function automatic logic signed [SAMPLE_W-1:0] neg_sat(input logic signed [SAMPLE_W-1:0] x);
		if (x == MIN_S) begin
			return MAX_S;
		end
		return -x;
	endfunction

	cplx_t src;
	cplx_t rotd;
	logic  out_valid_q;
	cplx_t out_q;
	logic  out_last_q;

	// Select zero for bins shifted in from outside the frame
	always_comb begin
		src = meta_s1.zero ? '0 : data_s1;
	end

	// Rotate by the frame's quarter-turn count
	always_comb begin
		case (meta_s1.rot)
			ROT_90: begin
				rotd.re   = neg_sat(src.imag);
				rotd.imag = src.re;
			end
			ROT_180: begin
				rotd.re   = neg_sat(src.re);
				rotd.imag = neg_sat(src.imag);
			end
			ROT_270: begin
				rotd.re   = src.imag;
				rotd.imag = neg_sat(src.re);
			end
			default: begin
				rotd = src;
			end
		endcase
	end

	// Load the result register whenever it is empty or being drained
	assign take_s1 = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take_s1) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && valid_s1) begin
			out_q      <= rotd;
			out_last_q <= meta_s1.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.imag, out_q.re};
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

// ----- hdl/spectral_bin_shifter.sv -----
// ----------------------------------------------------------------------------
// spectral_bin_shifter
// Frequency shift by moving FFT bins through a frame store, with an
// optional per-frame phase rotation for odd shifts.
// ----------------------------------------------------------------------------
//  channel   dir   handshake            payload
//  s_*       in    s_tvalid / s_tready  s_tdata: bin_real, bin_imag
//  m_*       out   m_tvalid / m_tready  m_tdata: out_real, out_imag; m_tlast: frame_end
//  cfg_*     in    cfg_wr_en            cfg_index, cfg_data
//
//  A frame loads NUM_BINS bins, one bin per accepted request, then emits
//  NUM_BINS bins at one bin per cycle while the master side accepts them,
//  set by the store's single read port. No bins are taken while a frame is
//  emitted. The store needs no clearing after reset. A stalled master side
//  holds the result register and the read stage; reads resume when the
//  result register drains.
// ----------------------------------------------------------------------------
`default_nettype none

module spectral_bin_shifter #(
	parameter int NUM_BINS = sbs_pkg::NUM_BINS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [sbs_pkg::TDATA_W-1:0]     s_tdata,   // bin_real [23:0], bin_imag [47:24]
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [sbs_pkg::TDATA_W-1:0]          m_tdata,   // out_real [23:0], out_imag [47:24]
	output logic                                 m_tlast,   // frame_end
	input  wire logic                            cfg_wr_en,
	input  wire logic [sbs_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [sbs_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import sbs_pkg::*;

`include "assert_macros.svh"

	localparam int ADDR_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(NUM_BINS - 1);

	typedef enum logic [1:0] {
		ST_LOAD = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	state_t              state_q;
	logic [ADDR_W-1:0]   load_idx_q;
	logic [ADDR_W-1:0]   rd_k_q;
	logic [1:0]          phase_q;
	rot_t                rot_q;
	logic                enable_q;
	logic [SHIFT_W-1:0]  shift_q;
	logic [OVL_W-1:0]    overlap_q;

	logic                in_accept;
	logic                last_load;
	logic                issue;
	logic                last_read;
	logic                take_s1;
	logic                valid_s1;
	rd_meta_t            meta_s1;
	cplx_t               wr_data;
	cplx_t               rd_data_s1;
	rot_t                rot_next;
	logic [1:0]          phase_next;
	logic [1:0]          phase_inc;
	logic [SRC_W-1:0]    src;
	logic [SRC_W-1:0]    shift_ext;
	logic                in_range;

	assign s_tready  = (state_q == ST_LOAD);
	assign in_accept = s_tvalid && s_tready;
	assign last_load = (load_idx_q == LAST_IDX);
	assign wr_data   = '{imag: s_tdata[TDATA_W-1:SAMPLE_W], re: s_tdata[SAMPLE_W-1:0]};

	// Issue a read when the read stage is empty or moving on
	assign issue     = (state_q == ST_EMIT) && (!valid_s1 || take_s1);
	assign last_read = (rd_k_q == LAST_IDX);

	// Source bin of the output bin being read
	assign shift_ext = enable_q ? {{(SRC_W-SHIFT_W){shift_q[SHIFT_W-1]}}, shift_q} : '0;
	assign src       = {{(SRC_W-ADDR_W){1'b0}}, rd_k_q} - shift_ext;
	assign in_range  = !src[SRC_W-1] && (src < SRC_W'(NUM_BINS));

	// Work out this frame's rotation and the phase left for the next one
	assign phase_inc = phase_q + 2'd1;
	always_comb begin
		rot_next   = ROT_0;
		phase_next = phase_q;
		if (enable_q && shift_q[0]) begin
			case (overlap_q)
				OVL_HALF: begin
					if (phase_inc == 2'd2) begin
						rot_next   = ROT_180;
						phase_next = 2'd0;
					end else begin
						phase_next = phase_inc;
					end
				end
				OVL_QUARTER: begin
					rot_next   = rot_t'(phase_q);
					phase_next = phase_inc;
				end
				default: begin
					rot_next   = ROT_0;
					phase_next = phase_q;
				end
			endcase
		end
	end

	// Sequence load and emit, take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			load_idx_q <= '0;
			rd_k_q     <= '0;
			phase_q    <= 2'd0;
			rot_q      <= ROT_0;
			enable_q   <= 1'b0;
			shift_q    <= '0;
			overlap_q  <= OVL_NONE;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_accept) begin
						if (last_load) begin
							load_idx_q <= '0;
							rd_k_q     <= '0;
							rot_q      <= rot_next;
							phase_q    <= phase_next;
							state_q    <= ST_EMIT;
						end else begin
							load_idx_q <= load_idx_q + 1'b1;
						end
					end
				end
				ST_EMIT: begin
					if (issue) begin
						if (last_read) begin
							rd_k_q  <= '0;
							state_q <= ST_LOAD;
						end else begin
							rd_k_q <= rd_k_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
			if (cfg_wr_en) begin
				case (cfg_reg_t'(cfg_index))
					REG_ENABLE: begin
						enable_q <= cfg_data[0];
						phase_q  <= 2'd0;
						rot_q    <= ROT_0;
					end
					REG_SHIFT: begin
						shift_q <= cfg_data[SHIFT_W-1:0];
						phase_q <= 2'd0;
						rot_q   <= ROT_0;
					end
					REG_OVERLAP: begin
						overlap_q <= cfg_data[OVL_W-1:0];
						phase_q   <= 2'd0;
						rot_q     <= ROT_0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Advance the read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (issue) begin
			valid_s1 <= 1'b1;
		end else if (take_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			meta_s1 <= '{rot: rot_q, zero: !in_range, last: last_read};
		end
	end

	sbs_bin_store #(
		.DEPTH  (NUM_BINS),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk        (clk),
		.wr_en      (in_accept),
		.wr_addr    (load_idx_q),
		.wr_data    (wr_data),
		.rd_en      (issue && in_range),
		.rd_addr    (src[ADDR_W-1:0]),
		.rd_data_s1 (rd_data_s1)
	);

	sbs_rotator u_rotator (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.meta_s1  (meta_s1),
		.data_s1  (rd_data_s1),
		.take_s1  (take_s1),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	`SBS_ASSERT_RST(a_load_idx_range, clk, arst_n, load_idx_q <= LAST_IDX, "load index past frame")
	`SBS_ASSERT_RST(a_last_bin_to_emit, clk, arst_n, (in_accept && last_load) |=> (state_q == ST_EMIT && rd_k_q == '0), "last bin did not start emit")
	`SBS_ASSERT_RST(a_last_read_to_load, clk, arst_n, (issue && last_read) |=> (state_q == ST_LOAD && load_idx_q == '0), "emit did not return to load")
	`SBS_ASSERT_RST(a_rot_needs_odd, clk, arst_n, (rot_q != ROT_0) |-> (enable_q && shift_q[0]), "rotation without odd shift")

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the spectral bin shifter. Frames of bins go in on
// the slave stream; a predictor in the bench shifts, zero-fills and rotates
// each completed frame and the output stream is checked bin by bin against
// it. Configuration changes only between frames with the pipe drained, and
// both streams idle and stall at random, with one long output stall.
// ----------------------------------------------------------------------------

module tb;
	import sbs_pkg::*;

	localparam int N_BINS        = NUM_BINS_DEF;
	localparam int STORE_DEPTH   = 64;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES  = 20;
	localparam int HOLD_CYCLES   = 400;
	localparam int RANDOM_BINS   = 33;
	localparam int MAX_REPORTS   = 10;
	localparam longint LIMIT_NS  = 1000000;

	localparam logic signed [SAMPLE_W-1:0] S_MAX = 24'sh7FFFFF;
	localparam logic signed [SAMPLE_W-1:0] S_MIN = 24'sh800000;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

	typedef enum {ACT_BIN, ACT_CFG, ACT_PAUSE} act_t;

	typedef struct {
		act_t                   act;
		cplx_t                  bin;
		logic [CFG_INDEX_W-1:0] idx;
		logic [CFG_DATA_W-1:0]  data;
	} tx_req_t;

	typedef struct packed {
		logic                       last;
		logic signed [SAMPLE_W-1:0] im;
		logic signed [SAMPLE_W-1:0] re;
	} bin_out_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	cplx_t                  s_tdata   = '0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [TDATA_W-1:0]     m_tdata;
	logic                   m_tlast;
	logic                   cfg_wr_en = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	// Stimulus and expectations
	tx_req_t  pending[$];
	bin_out_t expected_bins[$];

	// Predictor state
	cplx_t                     frame_store [STORE_DEPTH];
	int                        load_cnt  = 0;
	rot_t                      phase     = ROT_0;
	logic                      cfg_en    = 1'b0;
	logic signed [SHIFT_W-1:0] cfg_shift = '0;
	logic [OVL_W-1:0]          cfg_ovl   = OVL_NONE;

	logic signed [SAMPLE_W-1:0] corner [4];

	int err_count  = 0;
	int rx_count   = 0;
	int hold_at    = 0;
	int hold_left  = 0;
	bit hold_done  = 1'b0;
	logic rx_hold;

	int tx_gap = 0, tx_calm = 0, quiet_cycles = 0;
	int rx_gap = 0, rx_calm = 0;

	assign rx_hold = (hold_left != 0);

	spectral_bin_shifter #(
		.NUM_BINS(N_BINS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // bin_real [23:0], bin_imag [47:24]
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // out_real [23:0], out_imag [47:24]
		.m_tlast  (m_tlast),   // frame_end
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic void flag_error(input string msg);
		err_count++;
		if (err_count <= MAX_REPORTS) begin
			$display("ERROR: %s", msg);
		end
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] neg_clip(input logic signed [SAMPLE_W-1:0] x);
		if (x == S_MIN) begin
			return S_MAX;
		end
		return -x;
	endfunction

	// Apply one register write to the predictor; a known register clears the phase
	function automatic void apply_cfg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_ENABLE: begin
				cfg_en = data[0];
			end
			REG_SHIFT: begin
				cfg_shift = data[SHIFT_W-1:0];
			end
			REG_OVERLAP: begin
				cfg_ovl = data[OVL_W-1:0];
			end
			default: begin
				return;
			end
		endcase
		phase = ROT_0;
	endfunction

	// Store one bin; on the last bin of a frame, queue the shifted, rotated frame
	function automatic void load_bin(input cplx_t b);
		rot_t                       turn;
		logic [1:0]                 nxt;
		int                         src;
		cplx_t                      s;
		bin_out_t                   r;
		turn = ROT_0;
		frame_store[load_cnt] = b;
		if (load_cnt + 1 < N_BINS) begin
			load_cnt++;
			return;
		end
		load_cnt = 0;
		if (cfg_en && cfg_shift[0]) begin
			if (cfg_ovl == OVL_HALF) begin
				nxt = phase + 2'd1;
				if (nxt == ROT_180) begin
					turn  = ROT_180;
					phase = ROT_0;
				end else begin
					phase = rot_t'(nxt);
				end
			end else if (cfg_ovl == OVL_QUARTER) begin
				turn  = phase;
				phase = rot_t'(phase + 2'd1);
			end
		end
		for (int k = 0; k < N_BINS; k++) begin
			src = cfg_en ? k - int'(cfg_shift) : k;
			s = '0;
			if (src >= 0 && src < N_BINS) begin
				s = frame_store[src];
			end
			case (turn)
				ROT_90: begin
					r.re = neg_clip(s.imag);
					r.im = s.re;
				end
				ROT_180: begin
					r.re = neg_clip(s.re);
					r.im = neg_clip(s.imag);
				end
				ROT_270: begin
					r.re = s.imag;
					r.im = neg_clip(s.re);
				end
				default: begin
					r.re = s.re;
					r.im = s.imag;
				end
			endcase
			r.last = (k == N_BINS - 1);
			expected_bins.push_back(r);
		end
	endfunction

	// Mostly back to back, sometimes a few cycles, rarely a long gap
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(6, 30);
	endfunction

	function automatic void add_cfg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		tx_req_t t;
		t.act  = ACT_CFG;
		t.bin  = '0;
		t.idx  = idx;
		t.data = data;
		pending.push_back(t);
	endfunction

	// Queue one frame; corner frames cycle through the extreme sample values
	function automatic void add_frame(input bit corners, input bit with_pause);
		tx_req_t t;
		int      pause_at;
		pause_at = with_pause ? $urandom_range(1, N_BINS - 1) : -1;
		t.idx  = '0;
		t.data = '0;
		for (int k = 0; k < N_BINS; k++) begin
			if (k == pause_at) begin
				t.act = ACT_PAUSE;
				t.bin = '0;
				pending.push_back(t);
			end
			t.act = ACT_BIN;
			if (corners) begin
				t.bin.re   = corner[k % 4];
				t.bin.imag = corner[(k / 4) % 4];
			end else begin
				t.bin = cplx_t'(TDATA_W'({$urandom, $urandom}));
				if ($urandom_range(0, 7) == 0) begin
					t.bin.re = corner[$urandom_range(0, 3)];
				end
				if ($urandom_range(0, 7) == 0) begin
					t.bin.imag = corner[$urandom_range(0, 3)];
				end
			end
			pending.push_back(t);
		end
	endfunction

	// Sender: present queued requests, write registers once the pipe is drained
	always @(posedge clk) begin : drive
		logic                   nv;
		cplx_t                  nd;
		logic                   nwe;
		logic [CFG_INDEX_W-1:0] nidx;
		logic [CFG_DATA_W-1:0]  ndat;
		nv   = s_tvalid;
		nd   = s_tdata;
		nwe  = 1'b0;
		nidx = cfg_index;
		ndat = cfg_data;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				load_bin(s_tdata);
				nv = 1'b0;
				if (tx_calm > 0) begin
					tx_calm--;
					tx_gap = 0;
				end else begin
					tx_gap = pick_gap();
					if ($urandom_range(0, 40) == 0) begin
						tx_calm = $urandom_range(20, 90);
					end
				end
			end
			if (expected_bins.size() == 0) begin
				quiet_cycles++;
			end else begin
				quiet_cycles = 0;
			end
			if (!nv && pending.size() > 0) begin
				if (tx_gap > 0) begin
					tx_gap--;
				end else begin
					case (pending[0].act)
						ACT_BIN: begin
							nv = 1'b1;
							nd = pending[0].bin;
							void'(pending.pop_front());
						end
						ACT_CFG: begin
							if (quiet_cycles >= SETTLE_CYCLES) begin
								nwe  = 1'b1;
								nidx = pending[0].idx;
								ndat = pending[0].data;
								apply_cfg(nidx, ndat);
								void'(pending.pop_front());
							end
						end
						default: begin
							if (quiet_cycles >= SETTLE_CYCLES) begin
								void'(pending.pop_front());
							end
						end
					endcase
				end
			end
		end
		s_tvalid  <= nv;
		s_tdata   <= nd;
		cfg_wr_en <= nwe;
		cfg_index <= nidx;
		cfg_data  <= ndat;
	end

	// Receiver: check each result against the oldest expectation, stall at random
	always @(posedge clk) begin : watch
		logic     nr;
		bin_out_t want;
		cplx_t    got;
		nr = m_tready;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (expected_bins.size() == 0) begin
					flag_error($sformatf("unexpected result re=%0d im=%0d last=%0b",
						got.re, got.imag, m_tlast));
				end else begin
					want = expected_bins.pop_front();
					if (got.re !== want.re) begin
						flag_error($sformatf("result %0d out_real: expected %0d, got %0d",
							rx_count, want.re, got.re));
					end
					if (got.imag !== want.im) begin
						flag_error($sformatf("result %0d out_imag: expected %0d, got %0d",
							rx_count, want.im, got.imag));
					end
					if (m_tlast !== want.last) begin
						flag_error($sformatf("result %0d frame_end: expected %0b, got %0b",
							rx_count, want.last, m_tlast));
					end
				end
				rx_count <= rx_count + 1;
				if (rx_calm > 0) begin
					rx_calm--;
					rx_gap = 0;
				end else begin
					rx_gap = pick_gap();
					if ($urandom_range(0, 40) == 0) begin
						rx_calm = $urandom_range(20, 90);
					end
				end
			end
			if (rx_hold) begin
				nr = 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				nr = 1'b0;
			end else begin
				nr = 1'b1;
			end
		end
		m_tready <= nr;
	end

	// Hold the output off for a long stretch once, so the input backs up
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
			end else if (!hold_done && rx_count >= hold_at) begin
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
			end
		end
	end

	initial begin
		int       random_bins;
		int       r;
		logic [CFG_DATA_W-1:0] shift_pick [9];
		corner = '{S_MAX, S_MIN, 24'sd0, -24'sd1};
		shift_pick = '{7'd63, 7'h41, 7'h40, 7'd0, 7'd1, 7'h7F, 7'd32, 7'h60, 7'd33};

		// Disabled: bins pass through, odd shift and quarter overlap change nothing
		add_cfg(REG_OVERLAP, CFG_DATA_W'(OVL_QUARTER));
		add_cfg(REG_SHIFT, 7'd1);
		add_frame(1'b1, 1'b0);

		// Quarter overlap, odd shift: four rotation steps; a write to the
		// unused index sits between steps and must leave the phase alone
		add_cfg(REG_ENABLE, 7'd1);
		add_frame(1'b1, 1'b0);
		add_frame(1'b1, 1'b0);
		add_cfg(REG_UNUSED, 7'h55);
		add_frame(1'b1, 1'b0);
		add_frame(1'b1, 1'b0);

		// Half overlap, shift down by one: no turn, then half a turn
		add_cfg(REG_SHIFT, 7'h7F);
		add_cfg(REG_OVERLAP, CFG_DATA_W'(OVL_HALF));
		add_frame(1'b1, 1'b0);
		add_frame(1'b1, 1'b0);

		// Stall the output while the first quarter-overlap frame drains,
		// with the next frame already offered
		hold_at = N_BINS + 5;

		// Random part: frames under random settings
		random_bins = 0;
		while (random_bins < RANDOM_BINS) begin
			if ($urandom_range(0, 3) != 0) begin
				add_cfg(REG_ENABLE, ($urandom_range(0, 3) != 0) ? 7'd1 : 7'd0);
			end
			if ($urandom_range(0, 3) != 0) begin
				r = $urandom_range(0, 2);
				if (r == 0) begin
					add_cfg(REG_SHIFT, shift_pick[$urandom_range(0, 8)]);
				end else if (r == 1) begin
					add_cfg(REG_SHIFT, CFG_DATA_W'($urandom_range(0, 127)));
				end else begin
					add_cfg(REG_SHIFT, CFG_DATA_W'($urandom_range(0, 16) - 8));
				end
			end
			if ($urandom_range(0, 2) != 0) begin
				add_cfg(REG_OVERLAP, CFG_DATA_W'(($urandom_range(0, 4) == 0) ? 2'd3 :
					OVL_W'($urandom_range(OVL_NONE, OVL_QUARTER))));
			end
			if ($urandom_range(0, 7) == 0) begin
				add_cfg(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 127)));
			end
			add_frame(1'b0, $urandom_range(0, 5) == 0);
			random_bins += N_BINS;
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || s_tvalid) begin
			@(posedge clk);
		end
		while (expected_bins.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (err_count == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

	// Give up on a hung run
	initial begin
		#(LIMIT_NS);
		$display("tb failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/sbs_pkg.sv
hdl/sbs_bin_store.sv
hdl/sbs_rotator.sv
hdl/spectral_bin_shifter.sv
verif/tb.sv
